@@ src/pcm_pkg.sv @@
// shared types, sizes and action codes for the path corridor merge block
package pcm_pkg;

  // storage sizes
  localparam int MAX_CORR = 64;
  localparam int MAX_VIS  = 16;
  localparam int CIDX_W   = $clog2(MAX_CORR);
  localparam int CCNT_W   = 7;
  localparam int VIDX_W   = $clog2(MAX_VIS);
  localparam int VCNT_W   = $clog2(MAX_VIS + 1);
  localparam int REF_W    = 32;
  localparam int CAP_W    = 7;

  // input actions
  localparam logic [1:0] ACT_CORR  = 2'd0;
  localparam logic [1:0] ACT_VIS   = 2'd1;
  localparam logic [1:0] ACT_MERGE = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]       action;
    logic [REF_W-1:0] poly_ref;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [REF_W-1:0]  corridor_ref;
    logic              has_entry;
    logic              is_last;
    logic [CCNT_W-1:0] new_length;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic srch_rd;
    logic srch_cmp;
    logic calc;
    logic copy_rd;
    logic copy_wr;
    logic vis_wr;
    logic emit_start;
    logic emit_ld;
    logic emit_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic corr_empty;
    logic vis_empty;
    logic hit;
    logic idx_zero;
    logic keep_zero;
    logic copy_last;
    logic vis_last;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

@@ src/pcm_ctrl.sv @@
// controller state machine for the path corridor merge block
module pcm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  output logic           in_stall,
  input  pcm_pkg::stat_t stat,
  output pcm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCMP   = 4'd2;
  localparam logic [3:0] S_CALC   = 4'd3;
  localparam logic [3:0] S_CRD    = 4'd4;
  localparam logic [3:0] S_CWR    = 4'd5;
  localparam logic [3:0] S_VIS    = 4'd6;
  localparam logic [3:0] S_EINIT  = 4'd7;
  localparam logic [3:0] S_EEMPTY = 4'd8;
  localparam logic [3:0] S_ERD    = 4'd9;
  localparam logic [3:0] S_ELD    = 4'd10;

  logic [3:0] state_r, state_nxt;

  // items are taken only between merges
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action == pcm_pkg::ACT_MERGE) begin
            if (stat.corr_empty || stat.vis_empty) state_nxt = S_EINIT;
            else state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        if (stat.hit) state_nxt = S_CALC;
        else if (stat.idx_zero) state_nxt = S_EINIT;
        else state_nxt = S_SRD;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = stat.keep_zero ? S_VIS : S_CRD;
      end
      S_CRD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_CWR;
      end
      S_CWR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = stat.copy_last ? S_VIS : S_CRD;
      end
      S_VIS: begin
        cmd.vis_wr = 1'b1;
        if (stat.vis_last) state_nxt = S_EINIT;
      end
      S_EINIT: begin
        cmd.emit_start = 1'b1;
        state_nxt      = stat.corr_empty ? S_EEMPTY : S_ERD;
      end
      S_EEMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ERD: begin
        state_nxt = S_ELD;
      end
      S_ELD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = stat.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/pcm_dpath.sv @@
// datapath of the path corridor merge block: stores, counters and output register
module pcm_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcm_pkg::in_item_t           in_data,
  input  logic                        cfg_valid,
  input  logic [pcm_pkg::CAP_W-1:0]   cfg_data,
  input  pcm_pkg::cmd_t               cmd,
  output pcm_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pcm_pkg::out_item_t          out_data
);

  localparam int CIW = pcm_pkg::CIDX_W;
  localparam int CCW = pcm_pkg::CCNT_W;
  localparam int VIW = pcm_pkg::VIDX_W;
  localparam int VCW = pcm_pkg::VCNT_W;
  localparam int RW  = pcm_pkg::REF_W;

  // stores
  logic [RW-1:0] corr_mem [pcm_pkg::MAX_CORR];
  logic [RW-1:0] vis_r    [pcm_pkg::MAX_VIS];

  logic [CCW-1:0] cc_r;
  logic [VCW-1:0] vc_r;
  logic [pcm_pkg::CAP_W-1:0] cap_r;
  logic [RW-1:0]  rdata_r;

  logic [CIW-1:0] idx_r;
  logic [CIW-1:0] hitc_r;
  logic [VIW-1:0] hitv_r;
  logic [CCW-1:0] req_r, keep_r;
  logic           back_r;
  logic [CIW-1:0] cpy_r;
  logic [VIW-1:0] vi_r;
  logic [CIW-1:0] k_r;

  logic            out_valid_r;
  pcm_pkg::out_item_t out_r;

  // effective capacity, clamped to 1..MAX_CORR
  logic [CCW-1:0] eff_cap;
  always_comb begin
    if (cap_r == '0) eff_cap = CCW'(1);
    else if (cap_r > CCW'(pcm_pkg::MAX_CORR)) eff_cap = CCW'(pcm_pkg::MAX_CORR);
    else eff_cap = cap_r;
  end

  // compare the read corridor entry against every visited lane, earliest wins
  logic           hit_any;
  logic [VIW-1:0] hit_j;
  always_comb begin
    hit_any = 1'b0;
    hit_j   = '0;
    for (int j = pcm_pkg::MAX_VIS - 1; j >= 0; j--) begin
      if ((VCW'(j) < vc_r) && (vis_r[j] == rdata_r)) begin
        hit_any = 1'b1;
        hit_j   = VIW'(j);
      end
    end
  end

  // split between reversed visited tail and kept corridor tail
  logic [CCW-1:0] req_full, req_c, keep_full, keep_c, base_c;
  always_comb begin
    req_full  = CCW'(vc_r) - CCW'(hitv_r);
    req_c     = (req_full > eff_cap) ? eff_cap : req_full;
    base_c    = CCW'(hitc_r) + CCW'(1);
    keep_full = cc_r - base_c;
    keep_c    = ((req_c + keep_full) > eff_cap) ? (eff_cap - req_c) : keep_full;
  end

  // copy addressing, backward when the tail moves to higher addresses
  logic [CIW-1:0] keep_m1, t_idx, src_a, dst_a;
  assign keep_m1 = CIW'(keep_r - CCW'(1));
  assign t_idx   = back_r ? (keep_m1 - cpy_r) : cpy_r;
  assign src_a   = hitc_r + CIW'(1) + t_idx;
  assign dst_a   = CIW'(req_r) + t_idx;

  // visited tail read, newest first
  logic [VIW-1:0] vis_a;
  assign vis_a = VIW'(vc_r - VCW'(1)) - vi_r;

  // memory port selects
  logic [CIW-1:0] raddr;
  logic           we;
  logic [CIW-1:0] waddr;
  logic [RW-1:0]  wdata;
  always_comb begin
    if (cmd.srch_rd) raddr = idx_r;
    else if (cmd.copy_rd) raddr = src_a;
    else raddr = k_r;
    we    = 1'b0;
    waddr = CIW'(cc_r);
    wdata = in_data.poly_ref;
    if (cmd.accept && (in_data.action == pcm_pkg::ACT_CORR) &&
        (cc_r < CCW'(pcm_pkg::MAX_CORR))) begin
      we = 1'b1;
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      waddr = dst_a;
      wdata = rdata_r;
    end else if (cmd.vis_wr) begin
      we    = 1'b1;
      waddr = CIW'(vi_r);
      wdata = vis_r[vis_a];
    end
  end

  // corridor memory
  always_ff @(posedge clk) begin
    if (we) corr_mem[waddr] <= wdata;
    rdata_r <= corr_mem[raddr];
  end

  // visited lanes
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.action == pcm_pkg::ACT_VIS) &&
        (vc_r < VCW'(pcm_pkg::MAX_VIS))) begin
      vis_r[VIW'(vc_r)] <= in_data.poly_ref;
    end
  end

  logic out_take, out_free;
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // counts, capacity and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= '0;
      vc_r        <= '0;
      cap_r       <= pcm_pkg::CAP_W'(pcm_pkg::MAX_CORR);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (cmd.accept) begin
        case (in_data.action)
          pcm_pkg::ACT_CORR:
            if (cc_r < CCW'(pcm_pkg::MAX_CORR)) cc_r <= cc_r + CCW'(1);
          pcm_pkg::ACT_VIS:
            if (vc_r < VCW'(pcm_pkg::MAX_VIS)) vc_r <= vc_r + VCW'(1);
          pcm_pkg::ACT_CLEAR:
            cc_r <= '0;
          default: ;
        endcase
      end
      if (cmd.vis_wr && stat.vis_last) cc_r <= req_r + keep_r;
      if (cmd.emit_start) vc_r <= '0;
      if (cmd.emit_ld || cmd.emit_empty) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  // walk indexes and merge split
  always_ff @(posedge clk) begin
    if (cmd.accept) idx_r <= CIW'(cc_r - CCW'(1));
    if (cmd.srch_cmp) begin
      if (hit_any) begin
        hitc_r <= idx_r;
        hitv_r <= hit_j;
      end else begin
        idx_r <= idx_r - CIW'(1);
      end
    end
    if (cmd.calc) begin
      req_r  <= req_c;
      keep_r <= keep_c;
      back_r <= (req_c > base_c);
      cpy_r  <= '0;
      vi_r   <= '0;
    end
    if (cmd.copy_wr) cpy_r <= cpy_r + CIW'(1);
    if (cmd.vis_wr) vi_r <= vi_r + VIW'(1);
    if (cmd.emit_start) k_r <= '0;
    if (cmd.emit_ld) k_r <= k_r + CIW'(1);
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_r.corridor_ref <= rdata_r;
      out_r.has_entry    <= 1'b1;
      out_r.is_last      <= stat.emit_last;
      out_r.new_length   <= cc_r;
    end else if (cmd.emit_empty) begin
      out_r.corridor_ref <= '0;
      out_r.has_entry    <= 1'b0;
      out_r.is_last      <= 1'b1;
      out_r.new_length   <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  always_comb begin
    stat.corr_empty = (cc_r == '0);
    stat.vis_empty  = (vc_r == '0);
    stat.hit        = hit_any;
    stat.idx_zero   = (idx_r == '0);
    stat.keep_zero  = (keep_c == '0);
    stat.copy_last  = (cpy_r == keep_m1);
    stat.vis_last   = (CCW'(vi_r) + CCW'(1) == req_r);
    stat.emit_last  = (CCW'(k_r) + CCW'(1) == cc_r);
    stat.out_free   = out_free;
  end

endmodule

@@ src/path_corridor_merge.sv @@
// top level of the path corridor merge block
// Usage: items arrive on in_valid/in_stall/in_data. Action 0 appends a
// polygon reference to the corridor, action 1 appends one to the visited
// list, action 3 empties the corridor; each gives no
// result. Action 2 merges the visited list into the corridor and sends the
// whole corridor out on out_valid/out_stall/out_data, one item per entry,
// is_last on the final one (a single empty item when the corridor is empty).
// Merge steps: corridor entries are scanned from the end until a common
// polygon is found, kept corridor entries are moved and visited entries
// placed, all through the corridor memory, then the result items are
// sent while the receiver keeps up.
// in_stall stays high during a merge, else appends are taken every cycle.
// cfg_valid/cfg_ready/cfg_data write path_capacity; cfg_ready is always high.
// A stalled receiver holds the output register and pauses the merge at its
// next result; the last result may wait while new items are taken.
// Reset (rst_n low, synchronous) empties both lists, sets capacity to 64 and
// drops any pending result; there is no memory clearing pass.
module path_corridor_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pcm_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pcm_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pcm_pkg::CAP_W-1:0] cfg_data
);

  pcm_pkg::cmd_t  cmd;
  pcm_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencing
  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  pcm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/path_corridor_merge_chk.sv @@
// checker for the path corridor merge block: watches the channels, predicts and compares
module path_corridor_merge_chk
  import pcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  output int unsigned       fail_count,
  output int unsigned       due_left,
  output int unsigned       entries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted state of the block
  logic [REF_W-1:0] corr_mem [MAX_CORR];
  int unsigned      corr_len;
  logic [REF_W-1:0] vis_mem [MAX_VIS];
  int unsigned      vis_len;
  logic [CAP_W-1:0] capacity;

  // corridor entries still to come out, oldest first
  out_item_t        due_entries [$];
  int unsigned      fails;
  int unsigned      seen;

  assign fail_count   = fails;
  assign entries_seen = seen;

  // print one line per mismatch and count it
  task automatic report_mismatch(string what, logic [REF_W-1:0] got, logic [REF_W-1:0] want);
    fails++;
    $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
  endtask

  // splice the reversed visited tail in front of the corridor past the latest common polygon
  function automatic void fold_visits();
    int unsigned      hit_c, hit_v, lim, tail, keep, n, i, j;
    bit               hit;
    logic [REF_W-1:0] fresh [MAX_CORR];
    hit   = 1'b0;
    hit_c = 0;
    hit_v = 0;
    for (i = corr_len; i > 0 && !hit; i--) begin
      for (j = 0; j < vis_len && !hit; j++) begin
        if (corr_mem[i-1] == vis_mem[j]) begin
          hit   = 1'b1;
          hit_c = i - 1;
          hit_v = j;
        end
      end
    end
    if (hit) begin
      // capacity 0 behaves as 1, anything above the store size as the store size
      lim = (capacity == 0) ? 1 : (capacity > MAX_CORR) ? MAX_CORR : capacity;
      tail = vis_len - hit_v;
      keep = corr_len - (hit_c + 1);
      if (tail > lim) tail = lim;
      if (tail + keep > lim) keep = lim - tail;
      n = 0;
      for (i = 0; i < tail; i++) fresh[n++] = vis_mem[vis_len - 1 - i];
      for (i = 0; i < keep; i++) fresh[n++] = corr_mem[hit_c + 1 + i];
      for (i = 0; i < n; i++) corr_mem[i] = fresh[i];
      corr_len = n;
    end
    vis_len = 0;
  endfunction

  // update the predicted state for one accepted item, queue any results
  function automatic void apply_item(in_item_t it);
    out_item_t r;
    int unsigned k;
    case (it.action)
      ACT_CORR: begin
        if (corr_len < MAX_CORR) corr_mem[corr_len++] = it.poly_ref;
      end
      ACT_VIS: begin
        if (vis_len < MAX_VIS) vis_mem[vis_len++] = it.poly_ref;
      end
      ACT_CLEAR: begin
        corr_len = 0;
      end
      default: begin
        fold_visits();
        if (corr_len == 0) begin
          r.corridor_ref = '0;
          r.has_entry    = 1'b0;
          r.is_last      = 1'b1;
          r.new_length   = '0;
          due_entries.insert(due_entries.size(), r);
        end else begin
          for (k = 0; k < corr_len; k++) begin
            r.corridor_ref = corr_mem[k];
            r.has_entry    = 1'b1;
            r.is_last      = (k + 1 == corr_len);
            r.new_length   = corr_len[CCNT_W-1:0];
            due_entries.insert(due_entries.size(), r);
          end
        end
      end
    endcase
  endfunction

  // compare one accepted result with the oldest expected entry
  task automatic check_entry(out_item_t got);
    out_item_t want;
    seen++;
    if (due_entries.size() == 0) begin
      report_mismatch("result with nothing expected, corridor_ref", got.corridor_ref, '0);
    end else begin
      want = due_entries.pop_front();
      if (got.corridor_ref !== want.corridor_ref)
        report_mismatch("corridor_ref", got.corridor_ref, want.corridor_ref);
      if (got.has_entry !== want.has_entry)
        report_mismatch("has_entry", got.has_entry, want.has_entry);
      if (got.is_last !== want.is_last)
        report_mismatch("is_last", got.is_last, want.is_last);
      if (got.new_length !== want.new_length)
        report_mismatch("new_length", got.new_length, want.new_length);
    end
  endtask

  initial begin
    fails    = 0;
    seen     = 0;
    due_left = 0;
    corr_len = 0;
    vis_len  = 0;
    capacity = 7'd64;
  end

  // results first: a result at this edge always belongs to an earlier merge
  always @(posedge clk) begin
    if (!rst_n) begin
      corr_len = 0;
      vis_len  = 0;
      capacity = 7'd64;
      due_entries.delete();
    end else begin
      if (out_valid && !out_stall) check_entry(out_data);
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) apply_item(in_data);
    end
    due_left <= due_entries.size();
  end

endmodule

@@ verif/path_corridor_merge_tb.sv @@
// testbench top for the path corridor merge block: clock, reset, stimulus and verdict
module path_corridor_merge_tb;
  import pcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_GOAL   = 330;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int unsigned      fail_count;
  int unsigned      due_left;
  int unsigned      entries_seen;
  int unsigned      cycles;
  int unsigned      items_sent;
  int unsigned      merges_sent;
  int unsigned      cap_writes;
  bit               burst;
  logic [REF_W-1:0] ref_pool [8];

  path_corridor_merge uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  path_corridor_merge_chk chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .due_left     (due_left),
    .entries_seen (entries_seen)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure: quiet stretches, short stalls and the odd long one
  initial begin
    int mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ((mode == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // sender gap before an item, none while in a burst
  task automatic sender_gap();
    int unsigned pick, gap;
    pick = $urandom_range(0, 9);
    gap  = 0;
    if (!burst) begin
      if (pick >= 5 && pick < 9) gap = $urandom_range(1, 3);
      else if (pick == 9) gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // offer one item and hold it until taken
  task automatic send_item(logic [1:0] action, logic [REF_W-1:0] poly);
    sender_gap();
    in_data  <= '{action: action, poly_ref: poly};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (action == ACT_MERGE) merges_sent++;
  endtask

  // wait until every expected result has come out and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (due_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // capacity write, only while the block is idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // references mostly from a small pool so that corridor and visits overlap
  function automatic logic [REF_W-1:0] pick_ref();
    if ($urandom_range(0, 9) < 7) return ref_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic void refill_pool();
    for (int i = 0; i < 8; i++) ref_pool[i] = $urandom();
  endfunction

  // one agent move: maybe clear, extend corridor, log visits, then merge
  task automatic move_step(int unsigned n_corr, int unsigned n_vis, bit wipe);
    if (wipe) send_item(ACT_CLEAR, $urandom());
    repeat (n_corr) send_item(ACT_CORR, pick_ref());
    repeat (n_vis) send_item(ACT_VIS, pick_ref());
    // stray items that break the usual order
    if ($urandom_range(0, 7) == 0)
      send_item(2'($urandom_range(0, 3)), $urandom());
    send_item(ACT_MERGE, $urandom());
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [8];
    logic [CAP_W-1:0] cap;
    int unsigned      phase, phase_start;
    cap_plan = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd3, 7'd2, 7'd63, 7'd65};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    cycles      = 0;
    items_sent  = 0;
    merges_sent = 0;
    cap_writes  = 0;
    burst       = 1'b0;
    refill_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty corridor merge at reset capacity
    send_item(ACT_MERGE, 32'hFFFF_FFFF);
    // no visits, corridor returned unchanged; reference extremes
    send_item(ACT_CORR, 32'h0000_0000);
    send_item(ACT_CORR, 32'hFFFF_FFFF);
    send_item(ACT_CORR, 32'h5A5A_5A5A);
    send_item(ACT_MERGE, 32'h0000_0000);
    // common polygon in the middle, visited tail reversed in front
    send_item(ACT_VIS, 32'hFFFF_FFFF);
    send_item(ACT_VIS, 32'h1234_5678);
    send_item(ACT_MERGE, 32'hA5A5_A5A5);
    // clear then merge gives the empty result
    send_item(ACT_CLEAR, 32'hFFFF_FFFF);
    send_item(ACT_MERGE, 32'h0000_0000);
    // repeated visit: earliest visited position wins
    send_item(ACT_CORR, 32'h0000_00A1);
    send_item(ACT_CORR, 32'h0000_00B2);
    send_item(ACT_CORR, 32'h0000_00C3);
    send_item(ACT_VIS, 32'h0000_00C3);
    send_item(ACT_VIS, 32'h0000_00D4);
    send_item(ACT_VIS, 32'h0000_00C3);
    send_item(ACT_MERGE, 32'h0000_0000);
    // no common polygon, visits still consumed
    send_item(ACT_VIS, 32'h0BAD_0001);
    send_item(ACT_MERGE, 32'h0000_0000);
    drain();

    // random phases, each under its own capacity
    phase = 0;
    while (phase < 8 || items_sent < ITEM_GOAL) begin
      cap = (phase < 8) ? cap_plan[phase] : 7'($urandom_range(0, 127));
      write_capacity(cap);
      phase_start = items_sent;
      if (phase == 2) begin
        // fill corridor and visited list past their ends
        send_item(ACT_CLEAR, $urandom());
        refill_pool();
        repeat (66) send_item(ACT_CORR, pick_ref());
        repeat (17) send_item(ACT_VIS, pick_ref());
        send_item(ACT_MERGE, $urandom());
      end
      while (items_sent - phase_start < 28) begin
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) refill_pool();
        if ($urandom_range(0, 5) == 0)
          move_step($urandom_range(0, 8), $urandom_range(10, 17), $urandom_range(0, 4) == 0);
        else
          move_step($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 4) == 0);
      end
      burst = 1'b0;
      drain();
      phase++;
    end

    repeat (16) @(posedge clk);
    $display("ran %0d items with %0d merges under %0d capacity settings", items_sent,
             merges_sent, cap_writes);
    $display("checked %0d corridor result items, %0d mismatches", entries_seen, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/pcm_pkg.sv
src/pcm_ctrl.sv
src/pcm_dpath.sv
src/path_corridor_merge.sv
verif/path_corridor_merge_chk.sv
verif/path_corridor_merge_tb.sv
